### src/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// shared types, register indexes and a fixed-point constant of the sphere
// voxel fill pipeline
// ----------------------------------------------------------------------------
package svf_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CENTRE_X  = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y  = 3'd1;
  localparam logic [2:0] REG_CENTRE_Z  = 3'd2;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd3;
  localparam logic [2:0] REG_INV_RSQ   = 3'd4;
  localparam logic [2:0] REG_GRADED    = 3'd5;
  localparam logic [2:0] REG_PEAK      = 3'd6;

  // 1.0 in q1.12
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  typedef struct packed {
    logic [6:0] voxel_x;
    logic [6:0] voxel_y;
    logic [6:0] voxel_z;
  } svf_in_t;

  typedef struct packed {
    logic        inside_res;
    logic [20:0] voxel_index;
    logic [15:0] refractivity;
  } svf_out_t;

  typedef struct packed {
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    logic [15:0] centre_z;
    logic [25:0] radius_sq;
    logic [48:0] inv_radius_sq;
    logic        graded;
    logic [15:0] peak_index;
  } svf_cfg_t;

  // beat from the distance front end to the grading back end
  typedef struct packed {
    logic        valid;
    logic [20:0] voxel_index;
    logic [31:0] dist_sq;
  } svf_dist_t;

endpackage

### src/svf_dist.sv
// ----------------------------------------------------------------------------
// svf_dist
// three-stage front end: axis offsets, squares, squared distance sum; also
// forms the linear voxel index
// ----------------------------------------------------------------------------
module svf_dist #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  svf_pkg::svf_in_t   in_data,
  input  svf_pkg::svf_cfg_t  cfg,
  output svf_pkg::svf_dist_t dist_o
);

  localparam logic [20:0] ROW_STEP   = 21'(GRID_WIDTH);
  localparam logic [20:0] SLICE_STEP = 21'(GRID_WIDTH * GRID_HEIGHT);

  // |coord*16 - centre|, exact in 17 bits, magnitude fits 16
  function automatic logic [15:0] axis_mag(input logic [6:0] coord, input logic [15:0] ctr);
    logic [16:0] diff;
    logic [16:0] neg;
    diff = {6'b0, coord, 4'b0} - {ctr[15], ctr};
    neg  = 17'd0 - diff;
    return diff[16] ? neg[15:0] : diff[15:0];
  endfunction

  // stage 1
  logic        v1_r;
  logic [15:0] mx_r, my_r, mz_r;
  logic [20:0] lin1_r;
  logic [20:0] lin_nxt;
  // stage 2
  logic        v2_r;
  logic [31:0] sx_r, sy_r, sz_r;
  logic [20:0] lin2_r;
  // stage 3
  logic        v3_r;
  logic [31:0] dist3_r;
  logic [20:0] lin3_r;
  logic [31:0] dist_nxt;

  assign lin_nxt = 21'(in_data.voxel_x) + 21'(in_data.voxel_y) * ROW_STEP
                 + 21'(in_data.voxel_z) * SLICE_STEP;
  assign dist_nxt = sx_r + sy_r + sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= axis_mag(in_data.voxel_x, cfg.centre_x);
    my_r    <= axis_mag(in_data.voxel_y, cfg.centre_y);
    mz_r    <= axis_mag(in_data.voxel_z, cfg.centre_z);
    lin1_r  <= lin_nxt;
    sx_r    <= 32'(mx_r) * 32'(mx_r);
    sy_r    <= 32'(my_r) * 32'(my_r);
    sz_r    <= 32'(mz_r) * 32'(mz_r);
    lin2_r  <= lin1_r;
    dist3_r <= dist_nxt;
    lin3_r  <= lin2_r;
  end

  assign dist_o.valid       = v3_r;
  assign dist_o.voxel_index = lin3_r;
  assign dist_o.dist_sq     = dist3_r;

endmodule

### src/svf_grade.sv
// ----------------------------------------------------------------------------
// svf_grade
// three-stage back end: radius compare and reciprocal products, ratio
// saturation, index blend into the output register
// ----------------------------------------------------------------------------
module svf_grade (
  input  logic               clk,
  input  logic               rst_n,
  input  svf_pkg::svf_dist_t dist_i,
  input  svf_pkg::svf_cfg_t  cfg,
  output logic               out_strobe,
  output svf_pkg::svf_out_t  out_data
);

  // stage 4
  logic        v4_r, in4_r;
  logic [56:0] ph_r;
  logic [55:0] pl_r;
  logic [20:0] lin4_r;
  // stage 5
  logic        v5_r, in5_r;
  logic [12:0] q5_r;
  logic [20:0] lin5_r;
  logic [57:0] qsum;
  logic [45:0] qraw;
  logic [12:0] q_nxt;
  // stage 6
  logic        v6_r;
  svf_pkg::svf_out_t out_r;
  svf_pkg::svf_out_t out_nxt;
  logic [12:0] w;
  logic [28:0] acc;

  // ratio d/r^2 in q.12, clamped at 1.0
  assign qsum  = {1'b0, ph_r} + 58'(pl_r[55:24]);
  assign qraw  = qsum[57:12];
  assign q_nxt = (qraw > 46'(svf_pkg::ONE_Q12)) ? svf_pkg::ONE_Q12 : qraw[12:0];

  // peak*w + 1.0*(1.0-w), with 1.0-w == q
  assign w   = svf_pkg::ONE_Q12 - q5_r;
  assign acc = 29'(cfg.peak_index) * 29'(w) + {4'b0, q5_r, 12'b0};

  always_comb begin
    out_nxt.inside_res  = in5_r;
    out_nxt.voxel_index = lin5_r;
    if (!in5_r) begin
      out_nxt.refractivity = 16'd0;
    end else if (cfg.graded) begin
      out_nxt.refractivity = acc[27:12];
    end else begin
      out_nxt.refractivity = cfg.peak_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= dist_i.valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    in4_r  <= dist_i.dist_sq <= {6'b0, cfg.radius_sq};
    ph_r   <= 57'(dist_i.dist_sq) * 57'(cfg.inv_radius_sq[48:24]);
    pl_r   <= 56'(dist_i.dist_sq) * 56'(cfg.inv_radius_sq[23:0]);
    lin4_r <= dist_i.voxel_index;
    in5_r  <= in4_r;
    q5_r   <= q_nxt;
    lin5_r <= lin4_r;
    out_r  <= out_nxt;
  end

  assign out_strobe = v6_r;
  assign out_data   = out_r;

endmodule

### src/sphere_voxel_fill.sv
// ----------------------------------------------------------------------------
// sphere_voxel_fill
// sphere voxelizer: inside test, linear voxel index and refractive index
// for one voxel coordinate per clock
// ----------------------------------------------------------------------------
// result: the strobe is registered through stages 1-6 after the start beat is taken
// throughput: one voxel per clock, set by the six-stage pipeline; busy never
//   rises and the result side cannot stall, so every stage advances each cycle
// reset: synchronous active-low rst_n clears the pipeline valid bits and
//   loads the register defaults (peak index 1.0, all else zero)
module sphere_voxel_fill #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // command side
  input  logic              start,
  output logic              busy,
  input  svf_pkg::svf_in_t  in_data,
  // result side, one beat per command
  output logic              out_strobe,
  output svf_pkg::svf_out_t out_data,
  // register write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [48:0]       cfg_data
);

  svf_pkg::svf_cfg_t  cfg_r;
  svf_pkg::svf_cfg_t  cfg_nxt;
  svf_pkg::svf_dist_t dist_beat;
  logic               in_fire;

  // fully pipelined: a new command is taken every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start & ~busy;

  // register file write decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        svf_pkg::REG_CENTRE_X:  cfg_nxt.centre_x      = cfg_data[15:0];
        svf_pkg::REG_CENTRE_Y:  cfg_nxt.centre_y      = cfg_data[15:0];
        svf_pkg::REG_CENTRE_Z:  cfg_nxt.centre_z      = cfg_data[15:0];
        svf_pkg::REG_RADIUS_SQ: cfg_nxt.radius_sq     = cfg_data[25:0];
        svf_pkg::REG_INV_RSQ:   cfg_nxt.inv_radius_sq = cfg_data;
        svf_pkg::REG_GRADED:    cfg_nxt.graded        = cfg_data[0];
        svf_pkg::REG_PEAK:      cfg_nxt.peak_index    = cfg_data[15:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_x      <= '0;
      cfg_r.centre_y      <= '0;
      cfg_r.centre_z      <= '0;
      cfg_r.radius_sq     <= '0;
      cfg_r.inv_radius_sq <= '0;
      cfg_r.graded        <= 1'b0;
      cfg_r.peak_index    <= 16'(svf_pkg::ONE_Q12);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stages 1-3: offsets, squares, squared distance
  svf_dist #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .dist_o   (dist_beat)
  );

  // stages 4-6: compare, reciprocal ratio, index blend
  svf_grade u_grade (
    .clk        (clk),
    .rst_n      (rst_n),
    .dist_i     (dist_beat),
    .cfg        (cfg_r),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
